[sv/lmfbs_pkg.sv]
// ============================================================================
// lmfbs_pkg: shared definitions for the LED matrix frame buffer scanner
// Item kinds, plane codes, memory address widths and panel defaults.
// ============================================================================
`default_nettype none

package lmfbs_pkg;

  // Default panel geometry
  localparam int PANEL_WIDTH_DEF  = 64;
  localparam int PANEL_HEIGHT_DEF = 32;

  // Fixed storage geometry
  localparam int ROW_W      = 4;   // scan row counter, sixteen store rows
  localparam int PLANE_AW   = 10;  // {plane, byte index}
  localparam int STORE_AW   = 10;  // {row, slot, byte in slot}
  localparam int ROW_BYTES  = 48;

  // Item kinds carried in tuser
  typedef enum logic [2:0] {
    KIND_SET   = 3'd0,
    KIND_CLR   = 3'd1,
    KIND_DRAW  = 3'd2,
    KIND_ZONE  = 3'd3,
    KIND_FILL  = 3'd4,
    KIND_SNAP  = 3'd5,
    KIND_TICK  = 3'd6
  } kind_e;

  // Colour plane codes
  localparam logic [1:0] PLANE_RED   = 2'd0;
  localparam logic [1:0] PLANE_GREEN = 2'd1;
  localparam logic [1:0] PLANE_BLUE  = 2'd2;
  localparam logic [1:0] PLANE_NONE  = 2'd3;

endpackage

`default_nettype wire

[sv/led_matrix_frame_buffer_scanner.sv]
// ============================================================================
// led_matrix_frame_buffer_scanner
// Three one-bit colour planes, a scan store and a row scanner for a two-half
// panel, driven by one read-modify-write unit under a small sequencer.
// ============================================================================
// Latency/throughput: one item at a time, taken only while idle.
//   Set or clear pixel: one byte read-modify-write; draw byte: eight pixels;
//   zone: each clipped pixel; fill: each used byte; snapshot: one read per byte.
// Refresh tick: first byte in the cycle after the transfer, then one byte per
//   cycle while the sink takes them, 48 bytes; the store read port sets this.
// Reset: asynchronous, active low; a clearing pass then zeroes every address of
//   the plane memory and the scan store, and no item is taken meanwhile.
`default_nettype none

module led_matrix_frame_buffer_scanner #(
  parameter int PANEL_WIDTH  = lmfbs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lmfbs_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: x_pos[7:0], y_pos[15:8], x_stop[23:16], y_stop[31:24],
  //        plane[33:32], value[41:34], zero fill[47:42]
  input  wire logic [47:0] s_axis_tdata_i,
  // tuser: kind[2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  // shift byte stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: row_address[3:0], shift_byte[11:4], zero fill[15:12]
  output logic [15:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int BPL       = PANEL_WIDTH / 8;       // bytes per panel line
  localparam int HALF      = PANEL_HEIGHT / 2;      // scan rows
  localparam int PIX_BYTES = PANEL_HEIGHT * BPL;    // bytes used per plane
  localparam int RW        = lmfbs_pkg::ROW_W;
  localparam int PAW       = lmfbs_pkg::PLANE_AW;
  localparam int SAW       = lmfbs_pkg::STORE_AW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PIX_RD, ST_PIX_WR, ST_FILL, ST_SNAP, ST_SNAP_END, ST_TICK
  } state_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  lmfbs_pkg::kind_e    kind_q, kind_d;
  logic [1:0]          plane_q, plane_d;
  logic [7:0]          cx_q, cx_d;       // pixel column, also fill byte counter
  logic [7:0]          cy_q, cy_d;       // pixel row
  logic [7:0]          x0_q, x0_d;       // zone left edge, for row wrap
  logic [7:0]          xe_q, xe_d;       // clipped zone right edge
  logic [7:0]          ye_q, ye_d;       // clipped zone bottom edge
  logic [7:0]          val_q, val_d;     // draw pattern, shifted left per pixel
  logic [2:0]          cnt_q, cnt_d;     // draw pixel counter
  logic [SAW-1:0]      clr_q, clr_d;     // clearing pass address
  logic [RW-1:0]       si_q, si_d;       // snapshot scan row
  logic [2:0]          sj_q, sj_d;       // snapshot byte in slot
  logic [2:0]          ss_q, ss_d;       // snapshot slot
  logic                sv_q, sv_d;       // snapshot store write pending
  logic [SAW-1:0]      sa_q, sa_d;       // its store address
  logic [RW-1:0]       row_q, row_d;     // current scan row
  logic [5:0]          byte_q, byte_d;   // byte index held in the output reg
  logic                mvalid_q, mvalid_d;

  // --------------------------------------------------------------------------
  // Memories and their control
  // --------------------------------------------------------------------------
  logic [7:0] pmem [2**PAW];
  logic [7:0] smem [2**SAW];
  logic [7:0] pmem_q;   // registered plane read data
  logic [7:0] smem_q;   // registered store read data, doubles as output byte

  logic           pm_we, pm_re, st_we, st_re;
  logic [PAW-1:0] pm_wa, pm_ra;
  logic [SAW-1:0] st_wa, st_ra;
  logic [7:0]     pm_wd, st_wd;

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pmem[pm_wa] <= pm_wd;
    end
    if (pm_re) begin
      pmem_q <= pmem[pm_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      smem[st_wa] <= st_wd;
    end
    if (st_re) begin
      smem_q <= smem[st_ra];
    end
  end

  // --------------------------------------------------------------------------
  // Input field decode
  // --------------------------------------------------------------------------
  logic [7:0] in_x, in_y, in_xs, in_ys, in_val;
  logic [1:0] in_plane;
  logic       in_xfer, out_xfer;
  logic [7:0] zone_xe, zone_ye;

  assign in_x     = s_axis_tdata_i[7:0];
  assign in_y     = s_axis_tdata_i[15:8];
  assign in_xs    = s_axis_tdata_i[23:16];
  assign in_ys    = s_axis_tdata_i[31:24];
  assign in_plane = s_axis_tdata_i[33:32];
  assign in_val   = s_axis_tdata_i[41:34];

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = mvalid_q && m_axis_tready_i;

  // clip the zone to the panel so every visited pixel is inside it
  assign zone_xe = (in_xs < 8'(PANEL_WIDTH))  ? in_xs : 8'(PANEL_WIDTH);
  assign zone_ye = (in_ys < 8'(PANEL_HEIGHT)) ? in_ys : 8'(PANEL_HEIGHT);

  // --------------------------------------------------------------------------
  // Shared pixel unit: address, bounds and bit update of one pixel
  // --------------------------------------------------------------------------
  logic [10:0] pix_prod;
  logic        pix_inb, pix_act, pix_on;
  logic [7:0]  pix_mask, pix_new;

  assign pix_prod = 11'(cy_q) * 11'(BPL) + 11'(cx_q[7:3]);
  assign pix_inb  = (cx_q < 8'(PANEL_WIDTH)) && (cy_q < 8'(PANEL_HEIGHT));
  assign pix_act  = (kind_q == lmfbs_pkg::KIND_DRAW) ? val_q[7] : 1'b1;
  assign pix_on   = (kind_q == lmfbs_pkg::KIND_SET) || (kind_q == lmfbs_pkg::KIND_DRAW);
  assign pix_mask = 8'h80 >> cx_q[2:0];
  assign pix_new  = pix_on ? (pmem_q | pix_mask) : (pmem_q & ~pix_mask);

  // Snapshot source: upper half rows for the first three slots
  logic [4:0]  snap_prow;
  logic [10:0] snap_prod;
  logic [1:0]  snap_plane;
  logic        snap_done;

  assign snap_prow = (ss_q < 3'd3) ? (5'(si_q) + 5'(HALF)) : 5'(si_q);
  assign snap_prod = 11'(snap_prow) * 11'(BPL) + 11'(sj_q);
  assign snap_done = (ss_q == 3'd5) && (sj_q == 3'(BPL - 1)) && (si_q == RW'(HALF - 1));

  always_comb begin
    case (ss_q)
      3'd0, 3'd3: snap_plane = lmfbs_pkg::PLANE_BLUE;
      3'd1, 3'd4: snap_plane = lmfbs_pkg::PLANE_GREEN;
      default:    snap_plane = lmfbs_pkg::PLANE_RED;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    plane_d  = plane_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    x0_d     = x0_q;
    xe_d     = xe_q;
    ye_d     = ye_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    si_d     = si_q;
    sj_d     = sj_q;
    ss_d     = ss_q;
    sv_d     = 1'b0;
    sa_d     = sa_q;
    row_d    = row_q;
    byte_d   = byte_q;
    mvalid_d = mvalid_q;

    pm_we = 1'b0;
    pm_wa = {plane_q, cx_q};
    pm_wd = val_q;
    pm_re = 1'b0;
    pm_ra = {plane_q, pix_prod[7:0]};
    st_we = sv_q;
    st_wa = sa_q;
    st_wd = pmem_q;
    st_re = 1'b0;
    st_ra = {row_q, byte_q + 6'd1};

    case (state_q)
      ST_CLEAR: begin
        // zero both memories, one address a cycle
        pm_we = 1'b1;
        pm_wa = clr_q;
        pm_wd = 8'h00;
        st_we = 1'b1;
        st_wa = clr_q;
        st_wd = 8'h00;
        clr_d = clr_q + SAW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          kind_d  = lmfbs_pkg::kind_e'(s_axis_tuser_i);
          plane_d = in_plane;
          cx_d    = in_x;
          cy_d    = in_y;
          x0_d    = in_x;
          xe_d    = zone_xe;
          ye_d    = zone_ye;
          val_d   = in_val;
          cnt_d   = 3'd0;
          case (s_axis_tuser_i)
            lmfbs_pkg::KIND_SET, lmfbs_pkg::KIND_CLR, lmfbs_pkg::KIND_DRAW: begin
              if (in_plane != lmfbs_pkg::PLANE_NONE) begin
                state_d = ST_PIX_RD;
              end
            end
            lmfbs_pkg::KIND_ZONE: begin
              // drop empty or fully clipped zones
              if (in_plane != lmfbs_pkg::PLANE_NONE && in_x < zone_xe && in_y < zone_ye) begin
                state_d = ST_PIX_RD;
              end
            end
            lmfbs_pkg::KIND_FILL: begin
              if (in_plane != lmfbs_pkg::PLANE_NONE) begin
                cx_d    = 8'd0;
                state_d = ST_FILL;
              end
            end
            lmfbs_pkg::KIND_SNAP: begin
              si_d    = '0;
              sj_d    = 3'd0;
              ss_d    = 3'd0;
              state_d = ST_SNAP;
            end
            lmfbs_pkg::KIND_TICK: begin
              // fetch byte zero of the current row into the output register
              st_re    = 1'b1;
              st_ra    = {row_q, 6'd0};
              byte_d   = 6'd0;
              mvalid_d = 1'b1;
              state_d  = ST_TICK;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_PIX_RD: begin
        pm_re   = 1'b1;
        state_d = ST_PIX_WR;
      end

      ST_PIX_WR: begin
        pm_we   = pix_inb && pix_act;
        pm_wa   = {plane_q, pix_prod[7:0]};
        pm_wd   = pix_new;
        state_d = ST_PIX_RD;
        case (kind_q)
          lmfbs_pkg::KIND_DRAW: begin
            cx_d  = cx_q + 8'd1;
            val_d = {val_q[6:0], 1'b0};
            cnt_d = cnt_q + 3'd1;
            if (cnt_q == 3'd7) begin
              state_d = ST_IDLE;
            end
          end
          lmfbs_pkg::KIND_ZONE: begin
            if (cx_q + 8'd1 != xe_q) begin
              cx_d = cx_q + 8'd1;
            end else if (cy_q + 8'd1 != ye_q) begin
              cx_d = x0_q;
              cy_d = cy_q + 8'd1;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_FILL: begin
        pm_we = 1'b1;
        cx_d  = cx_q + 8'd1;
        if (cx_q == 8'(PIX_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_SNAP: begin
        // read one plane byte; it lands in the store on the next cycle
        pm_re = 1'b1;
        pm_ra = {snap_plane, snap_prod[7:0]};
        sv_d  = 1'b1;
        sa_d  = {si_q, ss_q, sj_q};
        if (ss_q != 3'd5) begin
          ss_d = ss_q + 3'd1;
        end else begin
          ss_d = 3'd0;
          if (sj_q != 3'(BPL - 1)) begin
            sj_d = sj_q + 3'd1;
          end else begin
            sj_d = 3'd0;
            si_d = si_q + RW'(1);
          end
        end
        if (snap_done) begin
          state_d = ST_SNAP_END;
        end
      end

      ST_SNAP_END: begin
        // let the last store write retire before a tick can read
        state_d = ST_IDLE;
      end

      ST_TICK: begin
        if (out_xfer) begin
          if (byte_q == 6'(lmfbs_pkg::ROW_BYTES - 1)) begin
            mvalid_d = 1'b0;
            row_d    = (5'(row_q) + 5'd1 == 5'(HALF)) ? '0 : row_q + RW'(1);
            state_d  = ST_IDLE;
          end else begin
            // refetch behind the transfer; a stall holds the output register
            st_re  = 1'b1;
            byte_d = byte_q + 6'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      kind_q   <= lmfbs_pkg::KIND_SET;
      plane_q  <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      x0_q     <= '0;
      xe_q     <= '0;
      ye_q     <= '0;
      val_q    <= '0;
      cnt_q    <= '0;
      clr_q    <= '0;
      si_q     <= '0;
      sj_q     <= '0;
      ss_q     <= '0;
      sv_q     <= 1'b0;
      sa_q     <= '0;
      row_q    <= '0;
      byte_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      plane_q  <= plane_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x0_q     <= x0_d;
      xe_q     <= xe_d;
      ye_q     <= ye_d;
      val_q    <= val_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      si_q     <= si_d;
      sj_q     <= sj_d;
      ss_q     <= ss_d;
      sv_q     <= sv_d;
      sa_q     <= sa_d;
      row_q    <= row_d;
      byte_q   <= byte_d;
      mvalid_q <= mvalid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {4'b0000, smem_q, row_q};
  assign m_axis_tlast_o  = mvalid_q && (byte_q == 6'(lmfbs_pkg::ROW_BYTES - 1));

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_no_accept_while_shifting : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input taken while a row is shifting");

  a_row_burst_continues : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("row burst ended before its last byte");

  a_row_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> (5'(m_axis_tdata_o[3:0]) < 5'(HALF)))
    else $error("scan row outside the half panel");

  a_row_stable_in_burst : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && !m_axis_tlast_o) |=> $stable(m_axis_tdata_o[3:0]))
    else $error("row address changed within a row");
`endif

endmodule

`default_nettype wire

[tb/sv/lmfbs_scan_checker.sv]
// ============================================================================
// lmfbs_scan_checker: frame buffer predictor and shift byte scoreboard
// Watches both streams of the scanner, keeps its own copy of the colour
// planes, the scan store and the row counter, and compares every shift byte
// with the oldest byte still expected.
// ============================================================================

module lmfbs_scan_checker #(
  parameter int PANEL_WIDTH  = lmfbs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lmfbs_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  wire logic        item_ready_i,
  input  wire logic [47:0] item_data_i,
  input  wire logic [2:0]  item_kind_i,
  input  wire logic        beat_valid_i,
  input  wire logic        beat_ready_i,
  input  wire logic [15:0] beat_data_i,
  input  wire logic        beat_last_i,
  output int               fail_cnt_o,
  output int               pend_cnt_o
);

  localparam int LINE_BYTES = PANEL_WIDTH / 8;
  localparam int HALF_ROWS  = PANEL_HEIGHT / 2;

  typedef struct packed {
    logic [3:0] row;
    logic [7:0] pix;
    logic       last;
  } shift_beat_t;

  shift_beat_t shift_q[$];
  logic [7:0]  plane_mem [0:2][0:255];
  logic [7:0]  frame_store [0:767];
  logic [3:0]  scan_row;
  int          fail_cnt;

  function automatic void paint_pixel(logic [1:0] pl, int x, int y, logic on);
    int         idx;
    logic [7:0] mask;
    if (pl == lmfbs_pkg::PLANE_NONE || x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
    idx = y * LINE_BYTES + x / 8;
    if (idx >= 256) return;
    mask = 8'h80 >> (x % 8);
    if (on) plane_mem[pl][idx] = plane_mem[pl][idx] | mask;
    else plane_mem[pl][idx] = plane_mem[pl][idx] & ~mask;
  endfunction

  // Copy the planes into the scan store: upper half slots first, then lower.
  function automatic void latch_frame();
    int lo;
    int hi;
    int base;
    for (int r = 0; r < HALF_ROWS && r < 16; r++) begin
      base = r * lmfbs_pkg::ROW_BYTES;
      for (int b = 0; b < LINE_BYTES && b < 8; b++) begin
        lo = r * LINE_BYTES + b;
        hi = (r + HALF_ROWS) * LINE_BYTES + b;
        if (lo < 256 && hi < 256) begin
          frame_store[base + b]      = plane_mem[lmfbs_pkg::PLANE_BLUE][hi];
          frame_store[base + 8 + b]  = plane_mem[lmfbs_pkg::PLANE_GREEN][hi];
          frame_store[base + 16 + b] = plane_mem[lmfbs_pkg::PLANE_RED][hi];
          frame_store[base + 24 + b] = plane_mem[lmfbs_pkg::PLANE_BLUE][lo];
          frame_store[base + 32 + b] = plane_mem[lmfbs_pkg::PLANE_GREEN][lo];
          frame_store[base + 40 + b] = plane_mem[lmfbs_pkg::PLANE_RED][lo];
        end
      end
    end
  endfunction

  function automatic void scan_out_row();
    shift_beat_t beat;
    int          base;
    int          next_row;
    base = int'(scan_row) * lmfbs_pkg::ROW_BYTES;
    for (int k = 0; k < lmfbs_pkg::ROW_BYTES; k++) begin
      beat.row  = scan_row;
      beat.pix  = frame_store[base + k];
      beat.last = (k == lmfbs_pkg::ROW_BYTES - 1);
      shift_q.push_back(beat);
    end
    next_row = int'(scan_row) + 1;
    if (next_row >= HALF_ROWS) next_row = 0;
    scan_row = 4'(next_row);
  endfunction

  function automatic void apply_item(logic [2:0] kind, logic [47:0] data);
    int         x;
    int         y;
    int         xs;
    int         ys;
    logic [1:0] pl;
    logic [7:0] val;
    x   = int'(data[7:0]);
    y   = int'(data[15:8]);
    xs  = int'(data[23:16]);
    ys  = int'(data[31:24]);
    pl  = data[33:32];
    val = data[41:34];
    case (kind)
      lmfbs_pkg::KIND_SET, lmfbs_pkg::KIND_CLR:
        paint_pixel(pl, x, y, kind == lmfbs_pkg::KIND_SET);
      lmfbs_pkg::KIND_DRAW: begin
        // columns wrap at 256 before the panel test
        for (int i = 0; i < 8; i++)
          if (val[7 - i]) paint_pixel(pl, (x + i) % 256, y, 1'b1);
      end
      lmfbs_pkg::KIND_ZONE: begin
        for (int i = x; i < xs; i++)
          for (int j = y; j < ys; j++)
            paint_pixel(pl, i, j, 1'b0);
      end
      lmfbs_pkg::KIND_FILL: begin
        if (pl != lmfbs_pkg::PLANE_NONE)
          for (int k = 0; k < PANEL_HEIGHT * LINE_BYTES && k < 256; k++)
            plane_mem[pl][k] = val;
      end
      lmfbs_pkg::KIND_SNAP: latch_frame();
      lmfbs_pkg::KIND_TICK: scan_out_row();
      default: ;
    endcase
  endfunction

  function automatic void report(string what, int want, int got);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  function automatic void check_beat(logic [15:0] data, logic last);
    shift_beat_t want;
    if (shift_q.size() == 0) begin
      fail_cnt++;
      $display("%0t: unexpected shift byte, expected none, actual %0h last %0b",
               $time, data, last);
      return;
    end
    want = shift_q.pop_front();
    if (data[3:0] != want.row) report("row_address", int'(want.row), int'(data[3:0]));
    if (data[11:4] != want.pix) report("shift_byte", int'(want.pix), int'(data[11:4]));
    if (last != want.last) report("last", int'(want.last), int'(last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 3; p++)
        for (int k = 0; k < 256; k++)
          plane_mem[p][k] = 8'h00;
      for (int k = 0; k < 768; k++) frame_store[k] = 8'h00;
      scan_row = '0;
      shift_q.delete();
      fail_cnt = 0;
    end else begin
      if (item_valid_i && item_ready_i) apply_item(item_kind_i, item_data_i);
      if (beat_valid_i && beat_ready_i) check_beat(beat_data_i, beat_last_i);
    end
    fail_cnt_o <= fail_cnt;
    pend_cnt_o <= shift_q.size();
  end

endmodule

[tb/sv/tb.sv]
// ============================================================================
// tb: testbench top for the LED matrix frame buffer scanner
// Resets the block, sends a directed set of drawing, snapshot and refresh
// items, then random traffic with bursty input and a stalling sink, and
// gives the verdict from the failure count of the checker.
// ============================================================================

module tb;

  localparam int PANEL_W     = lmfbs_pkg::PANEL_WIDTH_DEF;
  localparam int PANEL_H     = lmfbs_pkg::PANEL_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD   = 400;   // sink hold-off, long enough to back up the block
  localparam int DRAIN_WAIT  = 200;

  // Unused kind code: the block must swallow it without output.
  localparam logic [2:0] KIND_SPARE = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        s_valid  = 1'b0;
  logic        s_ready;
  logic [47:0] s_data   = '0;
  logic [2:0]  s_user   = '0;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [15:0] m_data;
  logic        m_last;

  int fail_cnt;
  int pend_cnt;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int hold_seq   = 0;

  // receiver pattern state, owned by the receiver process
  int       hold_seen = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode   = RX_OPEN;

  led_matrix_frame_buffer_scanner #(
    .PANEL_WIDTH  (PANEL_W),
    .PANEL_HEIGHT (PANEL_H)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  lmfbs_scan_checker #(
    .PANEL_WIDTH  (PANEL_W),
    .PANEL_HEIGHT (PANEL_H)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item_valid_i (s_valid),
    .item_ready_i (s_ready),
    .item_data_i  (s_data),
    .item_kind_i  (s_user),
    .beat_valid_i (m_valid),
    .beat_ready_i (m_ready),
    .beat_data_i  (m_data),
    .beat_last_i  (m_last),
    .fail_cnt_o   (fail_cnt),
    .pend_cnt_o   (pend_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL led_matrix_frame_buffer_scanner");
      $finish;
    end
  end

  // Sink side: switch to a randomly chosen stall pattern whenever the last one
  // runs out, and hold off completely each time the stimulus asks.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_ready <= 1'b1;
        RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_ready <= ($urandom_range(0, 7) != 0);
        default:   m_ready <= ~m_ready;
      endcase
    end
  end

  // Offer one item and hold it until the transfer; then either keep valid
  // high for the next item of the burst or drop it for a random gap.
  task automatic send_item(input logic [2:0] kind, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] xs, input logic [7:0] ys,
                           input logic [1:0] pl, input logic [7:0] val);
    int gap;
    s_valid <= 1'b1;
    s_data  <= {6'b0, val, pl, ys, xs, y, x};
    s_user  <= kind;
    do @(posedge clk); while (!s_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Drop valid and wait until every expected shift byte has arrived.
  task automatic wait_all_shifted();
    s_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pend_cnt != 0);
  endtask

  // Mostly in-panel drawing with small zones, frequent snapshots and
  // refresh ticks; a share of items carries off-panel or full-range fields.
  task automatic send_random_item();
    int         pick;
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] xs;
    logic [7:0] ys;
    logic [1:0] pl;
    logic [7:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 25) kind = lmfbs_pkg::KIND_SET;
    else if (pick < 35) kind = lmfbs_pkg::KIND_CLR;
    else if (pick < 50) kind = lmfbs_pkg::KIND_DRAW;
    else if (pick < 62) kind = lmfbs_pkg::KIND_ZONE;
    else if (pick < 66) kind = lmfbs_pkg::KIND_FILL;
    else if (pick < 76) kind = lmfbs_pkg::KIND_SNAP;
    else if (pick < 98) kind = lmfbs_pkg::KIND_TICK;
    else kind = KIND_SPARE;
    pl  = ($urandom_range(0, 9) == 0) ? lmfbs_pkg::PLANE_NONE : 2'($urandom_range(0, 2));
    x   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, PANEL_W - 1));
    y   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, PANEL_H - 1));
    val = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      xs = 8'($urandom);
      ys = 8'($urandom);
    end else begin
      xs = x + 8'($urandom_range(0, 9));
      ys = y + 8'($urandom_range(0, 5));
    end
    send_item(kind, x, y, xs, ys, pl, val);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: edges of the panel, off-panel pixels, the unused plane code,
    // wrapping draw columns, empty and clipped zones, the spare kind.
    send_item(lmfbs_pkg::KIND_SET, 8'd0, 8'd0, 8'd0, 8'd0, lmfbs_pkg::PLANE_RED, 8'h00);
    send_item(lmfbs_pkg::KIND_SET, 8'd63, 8'd31, 8'd0, 8'd0, lmfbs_pkg::PLANE_GREEN, 8'h00);
    send_item(lmfbs_pkg::KIND_SET, 8'd64, 8'd0, 8'd0, 8'd0, lmfbs_pkg::PLANE_BLUE, 8'h00);
    send_item(lmfbs_pkg::KIND_SET, 8'd0, 8'd32, 8'd0, 8'd0, lmfbs_pkg::PLANE_BLUE, 8'h00);
    send_item(lmfbs_pkg::KIND_SET, 8'd255, 8'd255, 8'd255, 8'd255, lmfbs_pkg::PLANE_RED,
              8'hFF);
    send_item(lmfbs_pkg::KIND_SET, 8'd5, 8'd5, 8'd0, 8'd0, lmfbs_pkg::PLANE_NONE, 8'h00);
    send_item(lmfbs_pkg::KIND_DRAW, 8'd60, 8'd7, 8'd0, 8'd0, lmfbs_pkg::PLANE_RED, 8'hFF);
    send_item(lmfbs_pkg::KIND_DRAW, 8'd252, 8'd20, 8'd0, 8'd0, lmfbs_pkg::PLANE_GREEN, 8'hA5);
    send_item(lmfbs_pkg::KIND_DRAW, 8'd8, 8'd3, 8'd0, 8'd0, lmfbs_pkg::PLANE_NONE, 8'h81);
    send_item(lmfbs_pkg::KIND_FILL, 8'd0, 8'd0, 8'd0, 8'd0, lmfbs_pkg::PLANE_BLUE, 8'hFF);
    send_item(lmfbs_pkg::KIND_ZONE, 8'd4, 8'd2, 8'd20, 8'd30, lmfbs_pkg::PLANE_BLUE, 8'h00);
    send_item(lmfbs_pkg::KIND_ZONE, 8'd30, 8'd10, 8'd30, 8'd20, lmfbs_pkg::PLANE_BLUE, 8'h00);
    send_item(lmfbs_pkg::KIND_ZONE, 8'd40, 8'd9, 8'd12, 8'd255, lmfbs_pkg::PLANE_BLUE, 8'h00);
    send_item(lmfbs_pkg::KIND_ZONE, 8'd50, 8'd28, 8'd255, 8'd255, lmfbs_pkg::PLANE_BLUE,
              8'h00);
    send_item(lmfbs_pkg::KIND_ZONE, 8'd0, 8'd0, 8'd64, 8'd32, lmfbs_pkg::PLANE_NONE, 8'h00);
    send_item(lmfbs_pkg::KIND_CLR, 8'd63, 8'd31, 8'd0, 8'd0, lmfbs_pkg::PLANE_GREEN, 8'h00);
    send_item(lmfbs_pkg::KIND_CLR, 8'd0, 8'd0, 8'd0, 8'd0, lmfbs_pkg::PLANE_NONE, 8'h00);
    send_item(lmfbs_pkg::KIND_CLR, 8'd200, 8'd200, 8'd0, 8'd0, lmfbs_pkg::PLANE_RED, 8'h00);
    send_item(lmfbs_pkg::KIND_FILL, 8'd0, 8'd0, 8'd0, 8'd0, lmfbs_pkg::PLANE_NONE, 8'h55);
    send_item(KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, lmfbs_pkg::PLANE_NONE, 8'hFF);
    send_item(lmfbs_pkg::KIND_SNAP, 8'd0, 8'd0, 8'd0, 8'd0, lmfbs_pkg::PLANE_RED, 8'h00);
    repeat (3) send_item(lmfbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0,
                         lmfbs_pkg::PLANE_RED, 8'h00);

    // Pause the source until the sink has taken everything.
    wait_all_shifted();

    repeat (100) send_random_item();

    // Hold the sink off and keep offering ticks back to back so the block
    // backs up and stalls its input.
    burst_left = 20;
    hold_seq <= hold_seq + 1;
    repeat (12) send_item(lmfbs_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 2'($urandom), 8'($urandom));

    repeat (110) send_random_item();

    wait_all_shifted();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS led_matrix_frame_buffer_scanner");
    end else begin
      $display("FAIL led_matrix_frame_buffer_scanner");
    end
    $finish;
  end

endmodule
